### hdl/assert_macros.svh
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, cond) \
    label: assert property (@(posedge clk) (cond)) \
        else $error("assertion failed");

// Same-cycle implication, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/bsc_pkg.sv
// Shared constants, codes and the sine ROM for the sine commutator.
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int ANGLE_W  = 8;
    localparam int AMP_W    = 8;
    localparam int SINE_W   = 17;
    localparam int PROD_W   = SINE_W + AMP_W + 1;
    localparam int POS_W    = 16;
    localparam int DELTA_W  = 8;
    localparam int RISE_W   = 8;
    localparam int FALL_W   = 9;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_PHASES = 3;

    typedef logic [OP_W-1:0]    t_opcode;
    typedef logic [ANGLE_W-1:0] t_angle;
    typedef logic signed [SINE_W-1:0] t_sine;

    localparam t_opcode OP_POSITION = 2'd0;
    localparam t_opcode OP_STEP     = 2'd1;
    localparam t_opcode OP_OFF      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PITCH_AMP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROLL_AMP  = 1'b1;

    localparam t_angle PHASE_B_OFFSET = 8'd85;
    localparam t_angle PHASE_C_OFFSET = 8'd170;

    // 128 << 16: centers the phase value so the shifted result stays positive
    localparam logic signed [PROD_W-1:0] PHASE_BIAS = 26'sd8388608;
    localparam logic [FALL_W-1:0] PWM_CENTER = 9'd255;

    // round(sin(k*pi/128) * 32768), k = 0..64
    localparam t_sine QUARTER_SINE [0:64] = '{
            0,   804,  1608,  2411,  3212,  4011,  4808,  5602,
         6393,  7180,  7962,  8740,  9512, 10279, 11039, 11793,
        12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
        18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
        23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
        27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
        30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
        32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
        32768
    };

    // Full-wave sine from the quarter table by quadrant folding.
    function automatic t_sine sine_rom(input t_angle angle);
        logic [1:0] quad;
        logic [6:0] r;
        logic [6:0] r_mirror;
        t_sine      result;
        quad     = angle[7:6];
        r        = {1'b0, angle[5:0]};
        r_mirror = 7'd64 - r;
        case (quad)
            2'd0:    result = QUARTER_SINE[r];
            2'd1:    result = QUARTER_SINE[r_mirror];
            2'd2:    result = -QUARTER_SINE[r];
            default: result = -QUARTER_SINE[r_mirror];
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

### hdl/bsc_cmd_if.sv
// Command channel: valid/ready with the commutation request fields.
`timescale 1ns / 1ps
`default_nettype none

interface bsc_cmd_if;
    logic                                   valid;
    logic                                   ready;
    bsc_pkg::t_opcode                       opcode;
    logic                                   channel;
    logic                                   table_select;
    logic signed [bsc_pkg::POS_W-1:0]       position;
    logic signed [bsc_pkg::DELTA_W-1:0]     step_delta;

    modport source (output valid, opcode, channel, table_select, position, step_delta,
                    input ready);
    modport sink   (input valid, opcode, channel, table_select, position, step_delta,
                    output ready);
endinterface

`default_nettype wire

### hdl/bsc_res_if.sv
// Result channel: valid/ready with the three-phase compare values.
`timescale 1ns / 1ps
`default_nettype none

interface bsc_res_if;
    logic                           valid;
    logic                           ready;
    logic                           out_channel;
    logic [bsc_pkg::RISE_W-1:0]     phase_a_rise;
    logic [bsc_pkg::FALL_W-1:0]     phase_a_fall;
    logic [bsc_pkg::RISE_W-1:0]     phase_b_rise;
    logic [bsc_pkg::FALL_W-1:0]     phase_b_fall;
    logic [bsc_pkg::RISE_W-1:0]     phase_c_rise;
    logic [bsc_pkg::FALL_W-1:0]     phase_c_fall;

    modport source (output valid, out_channel, phase_a_rise, phase_a_fall,
                    phase_b_rise, phase_b_fall, phase_c_rise, phase_c_fall,
                    input ready);
    modport sink   (input valid, out_channel, phase_a_rise, phase_a_fall,
                    phase_b_rise, phase_b_fall, phase_c_rise, phase_c_fall,
                    output ready);
endinterface

`default_nettype wire

### hdl/bldc_sine_commutator.sv
// Sinusoidal three-phase commutator: angle, sine lookup, PWM compare values.
//
// Channels: i_cmd takes one request per valid/ready handshake; o_res gives one
// result per request whose channel exists (requests for a missing channel are
// taken and dropped). The user writes amplitudes on i_cfg_we/i_cfg_idx/i_cfg_data
// only while no request is in flight; the block itself does not enforce it.
// Path: a request accepted on i_cmd goes into the angle and request register,
// then through sine lookup, multiply and compare logic into the result
// register, which drives o_res.
// Throughput: one request per cycle while o_res is not held; the three phase
// multipliers between the request register and the result register set the cycle time.
// Reset: synchronous, active low; clears both valids, all stored step angles
// and both amplitudes.
// Stall: while o_res is held, the request register fills; i_cmd.ready drops
// only once both registers hold a request, and no request is lost.
`timescale 1ns / 1ps
`default_nettype none

module bldc_sine_commutator #(
    parameter int NUM_CHANNELS = 2
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    bsc_cmd_if.sink                                 i_cmd,
    bsc_res_if.source                               o_res
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NP    = bsc_pkg::NUM_PHASES;

    // configuration
    logic [bsc_pkg::AMP_W-1:0] r_pitch_amp;
    logic [bsc_pkg::AMP_W-1:0] r_roll_amp;

    // per-channel step angle
    bsc_pkg::t_angle r_step_angle [NUM_CHANNELS];

    // handshake
    logic w_adv1, w_adv2;
    logic w_accept, w_chan_ok;
    logic [IDX_W-1:0] w_idx;
    logic r_s1_valid, r_out_valid;

    // request register: angles
    bsc_pkg::t_angle w_base_angle;
    bsc_pkg::t_angle n_s1_angle [NP];
    bsc_pkg::t_angle r_s1_angle [NP];
    logic r_s1_chan, r_s1_tsel;

    // sine, multiply and compare logic
    logic [bsc_pkg::AMP_W-1:0] w_amp;
    logic signed [bsc_pkg::AMP_W:0] w_amp_s;
    logic signed [bsc_pkg::PROD_W-1:0] w_prod [NP];

    // output register
    logic signed [bsc_pkg::PROD_W-1:0] w_biased [NP];
    logic [bsc_pkg::RISE_W-1:0] w_level [NP];
    logic [bsc_pkg::RISE_W-1:0] n_out_rise [NP];
    logic [bsc_pkg::FALL_W-1:0] n_out_fall [NP];
    logic [bsc_pkg::RISE_W-1:0] r_out_rise [NP];
    logic [bsc_pkg::FALL_W-1:0] r_out_fall [NP];
    logic r_out_chan;

    assign w_adv2   = !r_out_valid || o_res.ready;
    assign w_adv1   = !r_s1_valid || w_adv2;
    assign w_accept = i_cmd.valid && w_adv1;
    assign w_chan_ok = (32'(i_cmd.channel) < NUM_CHANNELS);
    assign w_idx     = w_chan_ok ? IDX_W'(i_cmd.channel) : '0;

    assign i_cmd.ready = w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch_amp <= '0;
            r_roll_amp  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsc_pkg::REG_PITCH_AMP: r_pitch_amp <= i_cfg_data;
                bsc_pkg::REG_ROLL_AMP:  r_roll_amp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // angle selection; step mode reads and advances the channel's angle
    always_comb begin
        case (i_cmd.opcode)
            bsc_pkg::OP_POSITION:
                w_base_angle = i_cmd.position[10:3];
            bsc_pkg::OP_STEP:
                w_base_angle = bsc_pkg::ANGLE_W'(r_step_angle[w_idx]
                                                 + $unsigned(i_cmd.step_delta));
            default:
                w_base_angle = '0;
        endcase
        n_s1_angle[0] = w_base_angle;
        if (i_cmd.opcode == bsc_pkg::OP_POSITION || i_cmd.opcode == bsc_pkg::OP_STEP) begin
            n_s1_angle[1] = w_base_angle + bsc_pkg::PHASE_B_OFFSET;
            n_s1_angle[2] = w_base_angle + bsc_pkg::PHASE_C_OFFSET;
        end else begin
            // motor off or unused opcode: all phases at angle zero
            n_s1_angle[1] = '0;
            n_s1_angle[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_step_angle[i] <= '0;
            end
        end else if (w_accept && w_chan_ok && i_cmd.opcode == bsc_pkg::OP_STEP) begin
            r_step_angle[w_idx] <= w_base_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv1) begin
            r_s1_valid <= i_cmd.valid && w_chan_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1_angle <= n_s1_angle;
            r_s1_chan  <= i_cmd.channel;
            r_s1_tsel  <= i_cmd.table_select;
        end
    end

    assign w_amp   = r_s1_tsel ? r_roll_amp : r_pitch_amp;
    assign w_amp_s = $signed({1'b0, w_amp});

    // v = 128 + floor(prod / 65536); rise = 255 - v, fall = 255 + v
    always_comb begin
        for (int p = 0; p < NP; p++) begin
            w_prod[p]     = bsc_pkg::sine_rom(r_s1_angle[p]) * w_amp_s;
            w_biased[p]   = w_prod[p] + bsc_pkg::PHASE_BIAS;
            w_level[p]    = w_biased[p][23:16];
            n_out_rise[p] = ~w_level[p];
            n_out_fall[p] = bsc_pkg::PWM_CENTER + bsc_pkg::FALL_W'(w_level[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv2) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_out_rise <= n_out_rise;
            r_out_fall <= n_out_fall;
            r_out_chan <= r_s1_chan;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_channel  = r_out_chan;
    assign o_res.phase_a_rise = r_out_rise[0];
    assign o_res.phase_a_fall = r_out_fall[0];
    assign o_res.phase_b_rise = r_out_rise[1];
    assign o_res.phase_b_fall = r_out_fall[1];
    assign o_res.phase_c_rise = r_out_rise[2];
    assign o_res.phase_c_fall = r_out_fall[2];

endmodule

`default_nettype wire

### hdl/bsc_checker.sv
// Port-level checker for the sine commutator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bsc_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cmd_ready,
    input  wire logic                           i_res_valid,
    input  wire logic                           i_res_ready,
    input  wire logic [bsc_pkg::RISE_W-1:0]     i_a_rise,
    input  wire logic [bsc_pkg::FALL_W-1:0]     i_a_fall,
    input  wire logic [bsc_pkg::RISE_W-1:0]     i_b_rise,
    input  wire logic [bsc_pkg::FALL_W-1:0]     i_b_fall,
    input  wire logic [bsc_pkg::RISE_W-1:0]     i_c_rise,
    input  wire logic [bsc_pkg::FALL_W-1:0]     i_c_fall
);

    // compare edges are centered: rise + fall is always 510
    logic w_centered;
    assign w_centered =
        (bsc_pkg::FALL_W'(i_a_rise) + i_a_fall == 9'd510) &&
        (bsc_pkg::FALL_W'(i_b_rise) + i_b_fall == 9'd510) &&
        (bsc_pkg::FALL_W'(i_c_rise) + i_c_fall == 9'd510);

    `ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)
    `ASSERT_IMPLY(a_res_centered, i_clk, i_rst_n, i_res_valid, w_centered)
    `ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !i_res_valid, i_cmd_ready)
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !$past(!i_rst_n) || !i_res_valid)

endmodule

bind bldc_sine_commutator bsc_checker u_bsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cmd_ready (i_cmd.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_a_rise    (o_res.phase_a_rise),
    .i_a_fall    (o_res.phase_a_fall),
    .i_b_rise    (o_res.phase_b_rise),
    .i_b_fall    (o_res.phase_b_fall),
    .i_c_rise    (o_res.phase_c_rise),
    .i_c_fall    (o_res.phase_c_fall)
);

`default_nettype wire
